// ===== hw/rtl/budget_cache_oldest_eviction_top_macros.svh =====
`ifndef BUDGET_CACHE_OLDEST_EVICTION_TOP_MACROS_SVH
`define BUDGET_CACHE_OLDEST_EVICTION_TOP_MACROS_SVH

// check a property on the rising clock edge, off while reset is active
`define BCOE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a stalled beat holds its payload
`define BCOE_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

// ===== hw/rtl/bcoe_pkg.sv =====
package bcoe_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 16;

	localparam int CMD_W    = 3;
	localparam int KEY_W    = 16;
	localparam int PATH_W   = 16;
	localparam int FSIZE_W  = 40;
	localparam int BUDGET_W = 24;
	localparam int VOCAB_W  = 17;
	localparam int KB_W     = 9;
	localparam int TOTAL_W  = 13;
	localparam int EVICT_W  = 5;
	localparam int AGE_W    = 32;
	localparam int SUM_W    = 24;

	localparam logic [CMD_W-1:0] CMD_LOAD         = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNLOAD       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_EVICT_OLDEST = 3'd3;
	localparam logic [CMD_W-1:0] CMD_EVICT_ALL    = 3'd4;

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd1024;

	localparam logic [VOCAB_W-1:0] VOCAB_CAP     = 17'd128000;
	localparam logic [VOCAB_W-1:0] VOCAB_MIN     = 17'd1000;
	localparam logic [VOCAB_W-1:0] VOCAB_DEFAULT = 17'd32000;
	localparam logic [KB_W-1:0]    KB_MIN        = 9'd64;
	localparam int                 KB_SHIFT      = 8;

	localparam int                 RECIP_W     = 25;
	localparam int                 RECIP_SHIFT = 31;
	localparam logic [RECIP_W-1:0] RECIP_100   = 25'd21474837;
	localparam int                 SMALL_W     = 24;
	localparam logic [FSIZE_W-1:0] CAP_BYTES   = 40'd12800000;

	localparam logic [1:0] SCAN_KEY  = 2'd0;
	localparam logic [1:0] SCAN_OLD  = 2'd1;
	localparam logic [1:0] SCAN_FREE = 2'd2;

	typedef struct packed {
		logic capture;
		logic start_key;
		logic start_old;
		logic start_free;
		logic est;
		logic evict_old;
		logic unload_hit;
		logic clear_all;
		logic write_new;
		logic fail;
		logic respond;
	} ctl_cmd_t;

	typedef struct packed {
		logic             scan_done;
		logic             free_hit;
		logic             hit;
		logic             old_found;
		logic             over;
		logic             empty;
		logic             full;
		logic             out_busy;
		logic [CMD_W-1:0] code;
	} ctl_sts_t;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_KSCAN    = 11'b000_0000_0010,
		ST_DISPATCH = 11'b000_0000_0100,
		ST_EST      = 11'b000_0000_1000,
		ST_DECIDE   = 11'b000_0001_0000,
		ST_OSCAN    = 11'b000_0010_0000,
		ST_EVICT    = 11'b000_0100_0000,
		ST_OSCANF   = 11'b000_1000_0000,
		ST_FSCAN    = 11'b001_0000_0000,
		ST_WRITE    = 11'b010_0000_0000,
		ST_RESP     = 11'b100_0000_0000
	} state_t;

endpackage

// ===== hw/rtl/bcoe_ifs.sv =====
interface bcoe_req_if import bcoe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [KEY_W-1:0]   entry_key;
	logic [PATH_W-1:0]  path_tag;
	logic [FSIZE_W-1:0] src_bytes;

	modport source (output valid, command, entry_key, path_tag, src_bytes, input ready);
	modport sink (input valid, command, entry_key, path_tag, src_bytes, output ready);
endinterface

interface bcoe_rsp_if import bcoe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               ok;
	logic               present;
	logic               compatible;
	logic [VOCAB_W-1:0] vocab_est;
	logic [KB_W-1:0]    entry_kb;
	logic [TOTAL_W-1:0] total_kb;
	logic [EVICT_W-1:0] evicted;

	modport source (output valid, ok, present, compatible, vocab_est, entry_kb, total_kb,
		evicted, input ready);
	modport sink (input valid, ok, present, compatible, vocab_est, entry_kb, total_kb,
		evicted, output ready);
endinterface

interface bcoe_cfg_if import bcoe_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BUDGET_W-1:0] budget_kb;

	modport source (output valid, budget_kb, input ready);
	modport sink (input valid, budget_kb, output ready);
endinterface

// ===== hw/rtl/bcoe_ram.sv =====
module bcoe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/bcoe_ctrl.sv =====
module bcoe_ctrl import bcoe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture   = 1'b1;
					cmd.start_key = 1'b1;
					state_d       = ST_KSCAN;
				end
			end
			ST_KSCAN: begin
				if (sts.scan_done) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_RESP;
				if (sts.code == CMD_LOAD) begin
					if (!sts.hit) begin
						state_d = ST_EST;
					end
				end else if (sts.code == CMD_UNLOAD) begin
					cmd.unload_hit = 1'b1;
				end else if (sts.code == CMD_EVICT_OLDEST) begin
					cmd.start_old = 1'b1;
					state_d       = ST_OSCAN;
				end else if (sts.code == CMD_EVICT_ALL) begin
					cmd.clear_all = 1'b1;
				end
			end
			ST_EST: begin
				cmd.est = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.over) begin
					if (sts.empty) begin
						cmd.fail = 1'b1;
						state_d  = ST_RESP;
					end else begin
						cmd.start_old = 1'b1;
						state_d       = ST_OSCAN;
					end
				end else if (sts.full) begin
					cmd.start_old = 1'b1;
					state_d       = ST_OSCANF;
				end else begin
					cmd.start_free = 1'b1;
					state_d        = ST_FSCAN;
				end
			end
			ST_OSCAN: begin
				if (sts.scan_done) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				cmd.evict_old = sts.old_found;
				state_d       = (sts.code == CMD_LOAD) ? ST_DECIDE : ST_RESP;
			end
			ST_OSCANF: begin
				if (sts.scan_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_FSCAN: begin
				if (sts.free_hit) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_new = 1'b1;
				state_d       = ST_RESP;
			end
			ST_RESP: begin
				if (!sts.out_busy) begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/bcoe_dp.sv =====
module bcoe_dp import bcoe_pkg::*; #(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_cmd_t            cmd,
	output ctl_sts_t            sts,
	input  logic [CMD_W-1:0]    req_command,
	input  logic [KEY_W-1:0]    req_entry_key,
	input  logic [PATH_W-1:0]   req_path_tag,
	input  logic [FSIZE_W-1:0]  req_src_bytes,
	input  logic                cfg_valid,
	input  logic [BUDGET_W-1:0] cfg_budget_kb,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output logic                rsp_ok,
	output logic                rsp_present,
	output logic                rsp_compatible,
	output logic [VOCAB_W-1:0]  rsp_vocab_est,
	output logic [KB_W-1:0]     rsp_entry_kb,
	output logic [TOTAL_W-1:0]  rsp_total_kb,
	output logic [EVICT_W-1:0]  rsp_evicted
);

	localparam int IW  = $clog2(ENTRIES);
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int RW  = KW + PATH_W + VOCAB_W + KB_W + AGE_W;
	localparam int PW  = SMALL_W + RECIP_W;

	// input beat
	logic [CMD_W-1:0]   code_q;
	logic [KW-1:0]      key_q;
	logic [PATH_W-1:0]  path_q;
	logic [FSIZE_W-1:0] fsz_q;

	// estimate
	logic [PW-1:0]      prod_q;
	logic [VOCAB_W-1:0] new_vocab_q;
	logic [KB_W-1:0]    new_kb_q;
	logic [VOCAB_W-1:0] v_raw, v_est;
	logic [KB_W-1:0]    kb_raw, kb_est;

	// table state
	logic [ENTRIES-1:0]  valid_q;
	logic [CW-1:0]       cnt_q;
	logic [SUM_W-1:0]    sum_q;
	logic [AGE_W-1:0]    seq_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [EVICT_W-1:0]  ev_q;
	logic                ok_q;

	// scan
	logic          run_q;
	logic [1:0]    mode_q;
	logic [IW-1:0] idx_q;
	logic          rd_s1;
	logic [IW-1:0] rd_idx_s1;

	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic [PATH_W-1:0] hit_path_q;
	logic [VOCAB_W-1:0] hit_vocab_q;
	logic [KB_W-1:0]   hit_kb_q;

	logic             old_q;
	logic [IW-1:0]    old_idx_q;
	logic [KB_W-1:0]  old_kb_q;
	logic [AGE_W-1:0] best_dist_q;

	// response register
	logic               rsp_valid_q;
	logic               rsp_ok_q;
	logic               rsp_present_q;
	logic               rsp_compatible_q;
	logic [VOCAB_W-1:0] rsp_vocab_q;
	logic [KB_W-1:0]    rsp_kb_q;
	logic [TOTAL_W-1:0] rsp_total_q;
	logic [EVICT_W-1:0] rsp_evicted_q;

	logic [RW-1:0]      ram_wdata, ram_rdata;
	logic [KW-1:0]      rd_key;
	logic [PATH_W-1:0]  rd_path;
	logic [VOCAB_W-1:0] rd_vocab;
	logic [KB_W-1:0]    rd_kb;
	logic [AGE_W-1:0]   rd_age;
	logic [AGE_W-1:0]   rd_dist;
	logic               rd_v, key_match, old_better, scan_done, free_hit, full_now;
	logic [IW-1:0]      slot;
	logic               present_now;

	bcoe_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (cmd.write_new),
		.waddr (slot),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign ram_wdata = {key_q, path_q, new_vocab_q, new_kb_q, seq_q};
	assign {rd_key, rd_path, rd_vocab, rd_kb, rd_age} = ram_rdata;

	assign rd_v       = valid_q[rd_idx_s1];
	assign rd_dist    = seq_q - rd_age;
	assign key_match  = rd_s1 && (mode_q == SCAN_KEY) && rd_v && !hit_q && (rd_key == key_q);
	assign old_better = rd_s1 && (mode_q == SCAN_OLD) && rd_v && (!old_q || rd_dist > best_dist_q);
	assign scan_done  = rd_s1 && (rd_idx_s1 == IW'(ENTRIES - 1));
	assign free_hit   = run_q && (mode_q == SCAN_FREE) && !valid_q[idx_q];
	assign full_now   = (cnt_q == CW'(ENTRIES));
	assign slot       = full_now ? old_idx_q : idx_q;

	assign v_raw  = (fsz_q >= CAP_BYTES) ? VOCAB_CAP : prod_q[RECIP_SHIFT +: VOCAB_W];
	assign v_est  = (v_raw < VOCAB_MIN) ? VOCAB_DEFAULT : v_raw;
	assign kb_raw = v_est[VOCAB_W-1:KB_SHIFT];
	assign kb_est = (kb_raw < KB_MIN) ? KB_MIN : kb_raw;

	assign present_now = hit_q && valid_q[hit_idx_q];

	assign sts.scan_done = scan_done;
	assign sts.free_hit  = free_hit;
	assign sts.hit       = hit_q;
	assign sts.old_found = old_q;
	assign sts.over      = ({1'b0, sum_q} + (SUM_W + 1)'(new_kb_q)) > (SUM_W + 1)'(budget_q);
	assign sts.empty     = (cnt_q == '0);
	assign sts.full      = full_now;
	assign sts.out_busy  = rsp_valid_q && !rsp_ready;
	assign sts.code      = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			mode_q      <= SCAN_KEY;
			idx_q       <= '0;
			rd_s1       <= 1'b0;
			hit_q       <= 1'b0;
			old_q       <= 1'b0;
			valid_q     <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			seq_q       <= '0;
			budget_q    <= BUDGET_RESET;
			ev_q        <= '0;
			ok_q        <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				budget_q <= cfg_budget_kb;
			end

			rd_s1 <= run_q && (mode_q != SCAN_FREE);
			if (cmd.start_key || cmd.start_old || cmd.start_free) begin
				run_q  <= 1'b1;
				idx_q  <= '0;
				mode_q <= cmd.start_key ? SCAN_KEY : (cmd.start_old ? SCAN_OLD : SCAN_FREE);
			end else if (run_q) begin
				if (mode_q == SCAN_FREE) begin
					if (free_hit) begin
						run_q <= 1'b0;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end else if (idx_q == IW'(ENTRIES - 1)) begin
					run_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end

			if (cmd.start_key) begin
				hit_q <= 1'b0;
			end else if (key_match) begin
				hit_q <= 1'b1;
			end

			if (cmd.start_old) begin
				old_q <= 1'b0;
			end else if (old_better) begin
				old_q <= 1'b1;
			end

			if (cmd.capture) begin
				ev_q <= '0;
				ok_q <= 1'b1;
			end

			if (cmd.fail) begin
				ok_q <= 1'b0;
			end

			if (cmd.unload_hit && hit_q) begin
				valid_q[hit_idx_q] <= 1'b0;
				sum_q              <= sum_q - SUM_W'(hit_kb_q);
				cnt_q              <= cnt_q - CW'(1);
			end

			if (cmd.evict_old) begin
				valid_q[old_idx_q] <= 1'b0;
				sum_q              <= sum_q - SUM_W'(old_kb_q);
				cnt_q              <= cnt_q - CW'(1);
				ev_q               <= ev_q + EVICT_W'(1);
			end

			if (cmd.clear_all) begin
				valid_q <= '0;
				sum_q   <= '0;
				cnt_q   <= '0;
				ev_q    <= EVICT_W'(cnt_q);
			end

			if (cmd.write_new) begin
				valid_q[slot] <= 1'b1;
				seq_q         <= seq_q + AGE_W'(1);
				hit_q         <= 1'b1;
				if (full_now) begin
					sum_q <= sum_q - SUM_W'(old_kb_q) + SUM_W'(new_kb_q);
					ev_q  <= ev_q + EVICT_W'(1);
				end else begin
					sum_q <= sum_q + SUM_W'(new_kb_q);
					cnt_q <= cnt_q + CW'(1);
				end
			end

			if (cmd.respond) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q <= req_command;
			key_q  <= req_entry_key[KW-1:0];
			path_q <= req_path_tag;
			fsz_q  <= req_src_bytes;
		end
		prod_q    <= PW'(fsz_q[SMALL_W-1:0]) * PW'(RECIP_100);
		rd_idx_s1 <= idx_q;
		if (cmd.est) begin
			new_vocab_q <= v_est;
			new_kb_q    <= kb_est;
		end
		if (key_match) begin
			hit_idx_q   <= rd_idx_s1;
			hit_path_q  <= rd_path;
			hit_vocab_q <= rd_vocab;
			hit_kb_q    <= rd_kb;
		end else if (cmd.write_new) begin
			hit_idx_q   <= slot;
			hit_path_q  <= path_q;
			hit_vocab_q <= new_vocab_q;
			hit_kb_q    <= new_kb_q;
		end
		if (old_better) begin
			old_idx_q   <= rd_idx_s1;
			old_kb_q    <= rd_kb;
			best_dist_q <= rd_dist;
		end
		if (cmd.respond) begin
			rsp_ok_q         <= ok_q;
			rsp_present_q    <= present_now;
			rsp_compatible_q <= present_now && (hit_path_q == path_q);
			rsp_vocab_q      <= present_now ? hit_vocab_q : '0;
			rsp_kb_q         <= present_now ? hit_kb_q : '0;
			rsp_total_q      <= sum_q[TOTAL_W-1:0];
			rsp_evicted_q    <= ev_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp_ok         = rsp_ok_q;
	assign rsp_present    = rsp_present_q;
	assign rsp_compatible = rsp_compatible_q;
	assign rsp_vocab_est  = rsp_vocab_q;
	assign rsp_entry_kb   = rsp_kb_q;
	assign rsp_total_kb   = rsp_total_q;
	assign rsp_evicted    = rsp_evicted_q;

endmodule

// ===== hw/rtl/budget_cache_oldest_eviction_top.sv =====
// Sequence: every command first scans all entries for its key; lookup, unload and evict-all then respond.
// Evict-oldest adds an age scan; a load that misses adds one age scan per eviction plus
// a free-slot search, or an age scan that picks the entry to replace when the table is full.
// Throughput: one command at a time; the key scan over the entry RAM read port sets the floor.
// Reset: arst_n clears all valid bits, load sequence, total and evict count; budget goes to 1024.
module budget_cache_oldest_eviction_top import bcoe_pkg::*; #(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	bcoe_req_if.sink    req,
	bcoe_rsp_if.source  rsp,
	bcoe_cfg_if.sink    cfg
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	assign cfg.ready = 1'b1;

	bcoe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bcoe_dp #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_command    (req.command),
		.req_entry_key  (req.entry_key),
		.req_path_tag   (req.path_tag),
		.req_src_bytes  (req.src_bytes),
		.cfg_valid      (cfg.valid),
		.cfg_budget_kb  (cfg.budget_kb),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_ok         (rsp.ok),
		.rsp_present    (rsp.present),
		.rsp_compatible (rsp.compatible),
		.rsp_vocab_est  (rsp.vocab_est),
		.rsp_entry_kb   (rsp.entry_kb),
		.rsp_total_kb   (rsp.total_kb),
		.rsp_evicted    (rsp.evicted)
	);

endmodule

// ===== hw/rtl/bcoe_chk.sv =====
`include "budget_cache_oldest_eviction_top_macros.svh"

module bcoe_chk import bcoe_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_ok,
	input logic               rsp_present,
	input logic               rsp_compatible,
	input logic [VOCAB_W-1:0] rsp_vocab_est,
	input logic [KB_W-1:0]    rsp_entry_kb,
	input logic [TOTAL_W-1:0] rsp_total_kb,
	input logic [EVICT_W-1:0] rsp_evicted
);

	logic [2+VOCAB_W+KB_W+TOTAL_W+EVICT_W:0] rsp_beat;
	logic                                    sizes_ok;
	logic                                    absent_clear;

	assign rsp_beat     = {rsp_ok, rsp_present, rsp_compatible, rsp_vocab_est, rsp_entry_kb,
		rsp_total_kb, rsp_evicted};
	assign sizes_ok     = (rsp_entry_kb >= KB_MIN) && (rsp_vocab_est >= VOCAB_MIN);
	assign absent_clear = !rsp_compatible && (rsp_vocab_est == '0) && (rsp_entry_kb == '0);

	`BCOE_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, rsp_beat, "result beat changed")
	`BCOE_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "accept while busy")
	`BCOE_ASSERT(a_fail_absent, (rsp_valid && !rsp_ok) |-> !rsp_present, "failed load present")
	`BCOE_ASSERT(a_present_sizes, (rsp_valid && rsp_present) |-> sizes_ok, "entry below minimum")
	`BCOE_ASSERT(a_absent_zero, (rsp_valid && !rsp_present) |-> absent_clear, "absent entry data")

endmodule

bind budget_cache_oldest_eviction_top bcoe_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ok         (rsp.ok),
	.rsp_present    (rsp.present),
	.rsp_compatible (rsp.compatible),
	.rsp_vocab_est  (rsp.vocab_est),
	.rsp_entry_kb   (rsp.entry_kb),
	.rsp_total_kb   (rsp.total_kb),
	.rsp_evicted    (rsp.evicted)
);
